[hw/rtl/hcbd_pkg.sv]
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; used by hcbd_decode and http_chunked_body_decoder_top.
`default_nettype none

package hcbd_pkg;

  localparam int unsigned SizeBits = 32;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef logic [SizeBits-1:0] size_t;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_SPACES     = 4'd1,
    PH_DIGITS     = 4'd2,
    PH_EXT        = 4'd3,
    PH_LINE_LF    = 4'd4,
    PH_DATA       = 4'd5,
    PH_DATA_CR    = 4'd6,
    PH_DATA_LF    = 4'd7,
    PH_FINAL_CR   = 4'd8,
    PH_FINAL_LF   = 4'd9,
    PH_DONE       = 4'd10,
    PH_ERROR      = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_EMPTY_LINE = 3'd1,
    ERR_NO_DIGIT   = 3'd2,
    ERR_OVERFLOW   = 3'd3,
    ERR_CHUNK_CRLF = 3'd4,
    ERR_FINAL_CRLF = 3'd5,
    ERR_TRAILING   = 3'd6
  } err_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       message_done;
    err_t       error_code;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hcbd_decode.sv]
// Decoder state machine: phase, chunk size counter and sticky error.
// Depends on hcbd_pkg; one byte is consumed per enabled cycle.
`default_nettype none

module hcbd_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic              step_start,
  input  wire logic [7:0]        step_byte,
  output hcbd_pkg::result_t      step_res
);

  hcbd_pkg::phase_t phase_r, phase_nxt, phase_cur;
  hcbd_pkg::size_t  size_r, size_nxt, size_cur, size_dec;
  hcbd_pkg::err_t   err_r, err_nxt, err_cur;
  hcbd_pkg::hex_t   hex;
  logic             size_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbd_pkg::PH_LINE_START;
      size_r  <= '0;
      err_r   <= hcbd_pkg::ERR_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    // start of a new body restarts from the reset state
    phase_cur = step_start ? hcbd_pkg::PH_LINE_START : phase_r;
    size_cur  = step_start ? '0 : size_r;
    err_cur   = step_start ? hcbd_pkg::ERR_NONE : err_r;
    hex       = hcbd_pkg::hex_decode(step_byte);
    size_full = (size_cur[hcbd_pkg::SizeBits-1 -: 4] != 4'd0);
    size_dec  = size_cur - hcbd_pkg::size_t'(1);

    phase_nxt = phase_cur;
    size_nxt  = size_cur;
    err_nxt   = err_cur;
    step_res  = '0;

    case (phase_cur)
      hcbd_pkg::PH_LINE_START, hcbd_pkg::PH_SPACES: begin
        if (hex.is_hex) begin
          if (size_full) begin
            phase_nxt = hcbd_pkg::PH_ERROR;
            err_nxt   = hcbd_pkg::ERR_OVERFLOW;
          end else begin
            size_nxt  = {size_cur[hcbd_pkg::SizeBits-5:0], hex.value};
            phase_nxt = hcbd_pkg::PH_DIGITS;
          end
        end else if (step_byte == hcbd_pkg::ChSpace || step_byte == hcbd_pkg::ChTab) begin
          phase_nxt = hcbd_pkg::PH_SPACES;
        end else begin
          phase_nxt = hcbd_pkg::PH_ERROR;
          err_nxt   = (step_byte == hcbd_pkg::ChCr && phase_cur == hcbd_pkg::PH_LINE_START) ?
                      hcbd_pkg::ERR_EMPTY_LINE : hcbd_pkg::ERR_NO_DIGIT;
        end
      end
      hcbd_pkg::PH_DIGITS: begin
        if (hex.is_hex) begin
          if (size_full) begin
            phase_nxt = hcbd_pkg::PH_ERROR;
            err_nxt   = hcbd_pkg::ERR_OVERFLOW;
          end else begin
            size_nxt = {size_cur[hcbd_pkg::SizeBits-5:0], hex.value};
          end
        end else if (step_byte == hcbd_pkg::ChCr) begin
          phase_nxt = hcbd_pkg::PH_LINE_LF;
        end else begin
          phase_nxt = hcbd_pkg::PH_EXT;
        end
      end
      hcbd_pkg::PH_EXT: begin
        if (step_byte == hcbd_pkg::ChCr) phase_nxt = hcbd_pkg::PH_LINE_LF;
      end
      hcbd_pkg::PH_LINE_LF: begin
        if (step_byte == hcbd_pkg::ChLf) begin
          phase_nxt = (size_cur == '0) ? hcbd_pkg::PH_FINAL_CR : hcbd_pkg::PH_DATA;
        end else if (step_byte != hcbd_pkg::ChCr) begin
          phase_nxt = hcbd_pkg::PH_EXT;
        end
      end
      hcbd_pkg::PH_DATA: begin
        step_res.data_valid = 1'b1;
        step_res.data_byte  = step_byte;
        size_nxt            = size_dec;
        if (size_dec == '0) begin
          step_res.chunk_end = 1'b1;
          phase_nxt          = hcbd_pkg::PH_DATA_CR;
        end
      end
      hcbd_pkg::PH_DATA_CR: begin
        if (step_byte == hcbd_pkg::ChCr) begin
          phase_nxt = hcbd_pkg::PH_DATA_LF;
        end else begin
          phase_nxt = hcbd_pkg::PH_ERROR;
          err_nxt   = hcbd_pkg::ERR_CHUNK_CRLF;
        end
      end
      hcbd_pkg::PH_DATA_LF: begin
        if (step_byte == hcbd_pkg::ChLf) begin
          phase_nxt = hcbd_pkg::PH_LINE_START;
          size_nxt  = '0;
        end else begin
          phase_nxt = hcbd_pkg::PH_ERROR;
          err_nxt   = hcbd_pkg::ERR_CHUNK_CRLF;
        end
      end
      hcbd_pkg::PH_FINAL_CR: begin
        if (step_byte == hcbd_pkg::ChCr) begin
          phase_nxt = hcbd_pkg::PH_FINAL_LF;
        end else begin
          phase_nxt = hcbd_pkg::PH_ERROR;
          err_nxt   = hcbd_pkg::ERR_FINAL_CRLF;
        end
      end
      hcbd_pkg::PH_FINAL_LF: begin
        if (step_byte == hcbd_pkg::ChLf) begin
          phase_nxt = hcbd_pkg::PH_DONE;
        end else begin
          phase_nxt = hcbd_pkg::PH_ERROR;
          err_nxt   = hcbd_pkg::ERR_FINAL_CRLF;
        end
      end
      hcbd_pkg::PH_DONE: begin
        phase_nxt = hcbd_pkg::PH_ERROR;
        err_nxt   = hcbd_pkg::ERR_TRAILING;
      end
      default: begin
        phase_nxt = hcbd_pkg::PH_ERROR;
      end
    endcase

    step_res.message_done = (phase_nxt == hcbd_pkg::PH_DONE) &&
                            (err_nxt == hcbd_pkg::ERR_NONE);
    step_res.error_code   = err_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/http_chunked_body_decoder_top.sv]
// Top level of the HTTP chunked body decoder: input register, decoder, result register.
// Depends on hcbd_pkg and hcbd_decode.
`default_nettype none

// Decodes an HTTP/1.1 chunked body fed one byte per transfer and returns exactly one
// result per input byte. Sustained rate is one byte per clock while out_ready is high:
// the input register feeds the decoder's state update, whose result lands in the
// output register. A result is offered only once its byte has passed through both the
// input register and the output register. Both stages keep accepting while the
// downstream side is ready; when out_ready drops the output register holds, then the
// input register fills, and only then in_ready drops.
// Assert in_start_message with the first byte of a body to clear state and errors.
// out_error_code is sticky: once nonzero, later bytes produce no data until a restart.
module http_chunked_body_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_start_message,
  input  wire logic [7:0] in_in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_data_valid,
  output logic [7:0]      out_data_byte,
  output logic            out_chunk_end,
  output logic            out_message_done,
  output logic [2:0]      out_error_code
);

  logic              in_valid_r;
  logic              start_r;
  logic [7:0]        byte_r;
  logic              out_valid_r;
  logic              advance;
  hcbd_pkg::result_t step_res;
  hcbd_pkg::result_t res_r;

  // move the held byte through the decoder when the result slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register: control cleared by reset, payload loads on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      start_r <= in_start_message;
      byte_r  <= in_in_byte;
    end
  end

  hcbd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .step_start (start_r),
    .step_byte  (byte_r),
    .step_res   (step_res)
  );

  // result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = res_r.data_valid;
  assign out_data_byte    = res_r.data_byte;
  assign out_chunk_end    = res_r.chunk_end;
  assign out_message_done = res_r.message_done;
  assign out_error_code   = res_r.error_code;

`ifndef SYNTHESIS
  a_end_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chunk_end |-> out_data_valid)
    else $error("chunk end flagged without a data byte");

  a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_message_done |-> out_error_code == hcbd_pkg::ERR_NONE)
    else $error("message done reported together with an error");

  a_data_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_valid |-> out_error_code == hcbd_pkg::ERR_NONE)
    else $error("payload byte passed while an error is present");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(byte_r) && $stable(start_r))
    else $error("held input byte lost before reaching the decoder");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("decoded byte did not produce a result");
`endif

endmodule

`default_nettype wire
